// ===== sv/pdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants of the pendulum drive controller
// Beat payloads, decoded operation format and timing constants.
// ----------------------------------------------------------------------------
package pdc_pkg;

  // Timing constants, in ticks
  localparam logic [9:0] BumpTicks     = 10'd20;
  localparam logic [9:0] BumpWaitTicks = 10'd100;

  // Configuration register indexes
  localparam logic CfgSettleSamples  = 1'b0;
  localparam logic CfgReportInterval = 1'b1;

  // Input opcodes
  typedef enum logic [1:0] {
    OPC_TICK  = 2'd0,
    OPC_CHG_A = 2'd1,
    OPC_CHG_B = 2'd2,
    OPC_CMD   = 2'd3
  } opcode_e;

  // Command codes
  typedef enum logic [2:0] {
    CMD_START       = 3'd0,
    CMD_CALIBRATE   = 3'd1,
    CMD_STOP_KEEP   = 3'd2,
    CMD_STOP_LOADED = 3'd3,
    CMD_STOP_UNLOAD = 3'd4
  } cmd_e;

  // Report kinds
  typedef enum logic [2:0] {
    RPT_NONE       = 3'd0,
    RPT_POSITION   = 3'd1,
    RPT_CAL_SAMPLE = 3'd2,
    RPT_CALIBRATED = 3'd3,
    RPT_STOPPED    = 3'd4,
    RPT_CALIBRATING = 3'd5,
    RPT_STARTING   = 3'd6,
    RPT_WRONG_STATE = 3'd7
  } report_e;

  // Decoded operation classes
  typedef enum logic [2:0] {
    OP_TICK,
    OP_ENC_A,
    OP_ENC_B,
    OP_CMD,
    OP_NOP
  } op_kind_e;

  // Input beat
  typedef struct packed {
    logic [1:0] opcode;
    logic       pin_level;
    logic [2:0] command_code;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic [2:0]         report_kind;
    logic signed [15:0] position;
    logic               load_on;
    logic               drive_pin;
    logic               bump_pin;
  } out_beat_t;

  // Classified operation passed from front to back
  typedef struct packed {
    op_kind_e   kind;
    logic       level;
    cmd_e       cmd;
  } op_t;

endpackage

`default_nettype wire

// ===== sv/pendulum_drive_controller.sv =====
`default_nettype none
// Path: an accepted input beat is written into the queue, then executed into
// the output register, from which it leaves as an output beat.
// Throughput: one beat per cycle while the output side is not stalled.
// Reset: asynchronous, active low; mode returns to start calibration,
// registers to settle_samples 100 and report period 10.
// ----------------------------------------------------------------------------
// pendulum_drive_controller: pendulum drive and calibration controller
// Tracks a quadrature position, sequences calibration, bump and drive pins
// and reports position on a tick-based interval.
// ----------------------------------------------------------------------------
module pendulum_drive_controller import pdc_pkg::*; (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        cfg_we_i,
  input  var logic        cfg_addr_i,
  input  var logic [15:0] cfg_wdata_i,
  input  var in_beat_t    in_data_i,
  input  var logic        in_valid_i,
  output var logic        in_stall_o,
  output var out_beat_t   out_data_o,
  output var logic        out_valid_o,
  input  var logic        out_stall_i
);

  op_t  push_op, pop_op;
  logic push_valid, q_full, pop_valid, pop;

  // Front: classify input beats
  pdc_front u_front (
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_o       (push_op),
    .op_valid_o (push_valid),
    .op_full_i  (q_full)
  );

  // Queue between front and back
  pdc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_data_i (push_op),
    .push_i      (push_valid),
    .full_o      (q_full),
    .pop_data_o  (pop_op),
    .pop_valid_o (pop_valid),
    .pop_i       (pop)
  );

  // Back: execute and register results
  pdc_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (pop_op),
    .op_valid_i  (pop_valid),
    .op_pop_o    (pop),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

// ===== sv/pdc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_front: input classifier
// Accepts input beats and turns them into decoded operations for the queue.
// ----------------------------------------------------------------------------
module pdc_front import pdc_pkg::*; (
  input  var in_beat_t in_data_i,
  input  var logic     in_valid_i,
  output var logic     in_stall_o,
  output var op_t      op_o,
  output var logic     op_valid_o,
  input  var logic     op_full_i
);

  // Backpressure comes straight from the queue
  assign in_stall_o = op_full_i;
  assign op_valid_o = in_valid_i;

  // Classify the beat; unknown command codes become no-ops
  always_comb begin
    op_o.level = in_data_i.pin_level;
    op_o.cmd   = CMD_START;
    case (opcode_e'(in_data_i.opcode))
      OPC_TICK:  op_o.kind = OP_TICK;
      OPC_CHG_A: op_o.kind = OP_ENC_A;
      OPC_CHG_B: op_o.kind = OP_ENC_B;
      OPC_CMD: begin
        if (in_data_i.command_code > CMD_STOP_UNLOAD) begin
          op_o.kind = OP_NOP;
        end else begin
          op_o.kind = OP_CMD;
          op_o.cmd  = cmd_e'(in_data_i.command_code);
        end
      end
      default:   op_o.kind = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/pdc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_queue: two-entry operation queue
// Decouples the classifier from the execution unit.
// ----------------------------------------------------------------------------
module pdc_queue import pdc_pkg::*; (
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var op_t  push_data_i,
  input  var logic push_i,
  output var logic full_o,
  output var op_t  pop_data_o,
  output var logic pop_valid_o,
  input  var logic pop_i
);

  op_t        mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign full_o      = (fill_q == 2'd2);
  assign pop_valid_o = (fill_q != 2'd0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;
  assign pop_data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// ===== sv/pdc_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_exec: execution unit
// Holds the controller state, applies one operation per cycle while the output
// is not stalled, and registers the resulting output beat.
// ----------------------------------------------------------------------------
module pdc_exec import pdc_pkg::*; (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        cfg_we_i,
  input  var logic        cfg_addr_i,
  input  var logic [15:0] cfg_wdata_i,
  input  var op_t         op_i,
  input  var logic        op_valid_i,
  output var logic        op_pop_o,
  output var out_beat_t   out_data_o,
  output var logic        out_valid_o,
  input  var logic        out_stall_i
);

  typedef enum logic [2:0] {
    M_START_CAL = 3'd0,
    M_AWAIT     = 3'd1,
    M_ZERO      = 3'd2,
    M_BUMP      = 3'd3,
    M_WAIT      = 3'd4,
    M_DRIVING   = 3'd5,
    M_STOPPED   = 3'd6
  } mode_e;

  logic [15:0] settle_samples_q;
  logic [9:0]  report_period_q;

  mode_e       mode_q, mode_d;
  logic [15:0] count_q, count_d;
  logic        level_a_q, level_a_d, level_b_q, level_b_d;
  logic [15:0] prev_q, prev_d;
  logic [15:0] settle_q, settle_d;
  logic [9:0]  timer_q, timer_d;
  logic        load_q, load_d, drive_q, drive_d, bump_q, bump_d;
  report_e     kind;

  out_beat_t   out_q;
  logic        out_valid_q;
  logic        fire;

  // Take an operation whenever the output register is free or draining
  assign op_pop_o    = !out_valid_q || !out_stall_i;
  assign fire        = op_pop_o && op_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next-state logic
  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    level_a_d = level_a_q;
    level_b_d = level_b_q;
    prev_d    = prev_q;
    settle_d  = settle_q;
    timer_d   = timer_q;
    load_d    = load_q;
    drive_d   = drive_q;
    bump_d    = bump_q;
    kind      = RPT_NONE;
    case (op_i.kind)
      OP_TICK: begin
        case (mode_q)
          M_AWAIT: begin
            if (count_q == prev_q) begin
              if (settle_q != 16'd0) settle_d = settle_q - 16'd1;
            end else begin
              settle_d = settle_samples_q;
            end
            prev_d = count_q;
            if (settle_d == 16'd0) begin
              load_d = 1'b0;
              mode_d = M_ZERO;
            end
            kind = RPT_CAL_SAMPLE;
          end
          M_ZERO: begin
            count_d = 16'd0;
            load_d  = 1'b0;
            drive_d = 1'b1;
            bump_d  = 1'b0;
            timer_d = BumpTicks;
            mode_d  = M_BUMP;
            kind    = RPT_CALIBRATED;
          end
          M_BUMP: begin
            if (timer_q <= 10'd1) begin
              bump_d  = 1'b1;
              timer_d = BumpWaitTicks;
              mode_d  = M_WAIT;
            end else begin
              timer_d = timer_q - 10'd1;
            end
          end
          M_WAIT: begin
            if (timer_q <= 10'd1) begin
              drive_d = 1'b0;
              bump_d  = 1'b1;
              load_d  = 1'b0;
              timer_d = report_period_q;
              mode_d  = M_DRIVING;
            end else begin
              timer_d = timer_q - 10'd1;
            end
          end
          M_DRIVING, M_STOPPED: begin
            if (mode_q == M_DRIVING) begin
              drive_d = 1'b0;
              load_d  = 1'b0;
            end else begin
              drive_d = 1'b1;
            end
            bump_d = 1'b1;
            // Report timer
            if (timer_q <= 10'd1) begin
              timer_d = report_period_q;
              kind    = RPT_POSITION;
            end else begin
              timer_d = timer_q - 10'd1;
            end
          end
          default: begin
            // Start calibration: apply load and begin sampling
            load_d   = 1'b1;
            drive_d  = 1'b1;
            bump_d   = 1'b1;
            prev_d   = 16'd0;
            settle_d = settle_samples_q;
            mode_d   = M_AWAIT;
          end
        endcase
      end
      OP_ENC_A: begin
        level_a_d = op_i.level;
        count_d   = (op_i.level != level_b_q) ? count_q + 16'd1 : count_q - 16'd1;
      end
      OP_ENC_B: begin
        level_b_d = op_i.level;
        count_d   = (op_i.level == level_a_q) ? count_q + 16'd1 : count_q - 16'd1;
      end
      OP_CMD: begin
        if (mode_q != M_DRIVING && mode_q != M_STOPPED) begin
          kind = RPT_WRONG_STATE;
        end else begin
          case (op_i.cmd)
            CMD_START: begin
              load_d  = 1'b0;
              drive_d = 1'b1;
              bump_d  = 1'b0;
              timer_d = BumpTicks;
              mode_d  = M_BUMP;
              kind    = RPT_STARTING;
            end
            CMD_CALIBRATE: begin
              load_d   = 1'b1;
              drive_d  = 1'b1;
              bump_d   = 1'b1;
              prev_d   = 16'd0;
              settle_d = settle_samples_q;
              mode_d   = M_AWAIT;
              kind     = RPT_CALIBRATING;
            end
            default: begin
              // Stop variants
              if (op_i.cmd == CMD_STOP_LOADED) load_d = 1'b1;
              else if (op_i.cmd == CMD_STOP_UNLOAD) load_d = 1'b0;
              drive_d = 1'b1;
              bump_d  = 1'b1;
              timer_d = report_period_q;
              mode_d  = M_STOPPED;
              kind    = RPT_STOPPED;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_samples_q <= 16'd100;
      report_period_q  <= 10'd10;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CfgSettleSamples) settle_samples_q <= cfg_wdata_i;
      if (cfg_addr_i == CfgReportInterval) report_period_q <= cfg_wdata_i[9:0];
    end
  end

  // Controller state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= M_START_CAL;
      count_q     <= 16'd0;
      level_a_q   <= 1'b0;
      level_b_q   <= 1'b0;
      prev_q      <= 16'd0;
      settle_q    <= 16'd0;
      timer_q     <= 10'd0;
      load_q      <= 1'b0;
      drive_q     <= 1'b0;
      bump_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        mode_q    <= mode_d;
        count_q   <= count_d;
        level_a_q <= level_a_d;
        level_b_q <= level_b_d;
        prev_q    <= prev_d;
        settle_q  <= settle_d;
        timer_q   <= timer_d;
        load_q    <= load_d;
        drive_q   <= drive_d;
        bump_q    <= bump_d;
      end
      if (op_pop_o) out_valid_q <= op_valid_i;
    end
  end

  // Output beat payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.report_kind <= kind;
      out_q.position    <= $signed(count_d);
      out_q.load_on     <= load_d;
      out_q.drive_pin   <= drive_d;
      out_q.bump_pin    <= bump_d;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_pendulum_drive_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pendulum_drive_controller: self-checking bench for the drive controller
// Feeds ticks, encoder edges and commands through the valid/stall input
// channel, predicts every result beat from a behavioral copy of the
// controller and compares each output beat field by field. Random gaps and
// back-pressure on both sides, several register settings including extremes.
// ----------------------------------------------------------------------------
module tb_pendulum_drive_controller;
  import pdc_pkg::*;

  // Controller sequencing states, as tracked by the predictor
  typedef enum logic [2:0] {
    MODE_START_CAL,
    MODE_SETTLING,
    MODE_ZERO,
    MODE_BUMP,
    MODE_WAIT,
    MODE_DRIVING,
    MODE_STOPPED
  } drive_mode_e;

  localparam logic [2:0] CmdUnknownFirst = 3'd5;
  localparam logic [2:0] CmdCodeLast     = 3'd7;
  localparam int unsigned SlowSettle     = 16;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned SqueezeCycles  = 80;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts one report beat per accepted input beat
  // --------------------------------------------------------------------------
  class report_scoreboard;
    logic [15:0] settle_samples  = 16'd100;
    logic [9:0]  report_period   = 10'd10;
    drive_mode_e mode            = MODE_START_CAL;
    logic [15:0] count           = '0;
    logic        level_a         = 1'b0;
    logic        level_b         = 1'b0;
    logic [15:0] previous_sample = '0;
    logic [15:0] settle_left     = '0;
    logic [9:0]  tick_timer      = '0;
    logic        load_level      = 1'b0;
    logic        drive_level     = 1'b0;
    logic        bump_level      = 1'b1;
    out_beat_t   expected_reports[$];
    int unsigned error_count     = 0;

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    // Load applied, pins released, sampling restarts from zero
    function void start_settling();
      load_level      = 1'b1;
      drive_level     = 1'b1;
      bump_level      = 1'b1;
      previous_sample = '0;
      settle_left     = settle_samples;
      mode            = MODE_SETTLING;
    endfunction

    function void start_bump();
      load_level  = 1'b0;
      drive_level = 1'b1;
      bump_level  = 1'b0;
      tick_timer  = BumpTicks;
      mode        = MODE_BUMP;
    endfunction

    // Report timer countdown; reloads and flags on expiry
    function bit report_due();
      if (tick_timer <= 10'd1) begin
        tick_timer = report_period;
        return 1'b1;
      end
      tick_timer = tick_timer - 10'd1;
      return 1'b0;
    endfunction

    function void predict_report(in_beat_t b);
      report_e   kind;
      out_beat_t want;
      kind = RPT_NONE;
      case (b.opcode)
        OPC_TICK: begin
          case (mode)
            MODE_SETTLING: begin
              if (count == previous_sample) begin
                if (settle_left != '0) settle_left = settle_left - 16'd1;
              end else begin
                settle_left = settle_samples;
              end
              previous_sample = count;
              if (settle_left == '0) begin
                load_level = 1'b0;
                mode       = MODE_ZERO;
              end
              kind = RPT_CAL_SAMPLE;
            end
            MODE_ZERO: begin
              count = '0;
              start_bump();
              kind = RPT_CALIBRATED;
            end
            MODE_BUMP: begin
              if (tick_timer <= 10'd1) begin
                bump_level = 1'b1;
                tick_timer = BumpWaitTicks;
                mode       = MODE_WAIT;
              end else begin
                tick_timer = tick_timer - 10'd1;
              end
            end
            MODE_WAIT: begin
              if (tick_timer <= 10'd1) begin
                drive_level = 1'b0;
                bump_level  = 1'b1;
                load_level  = 1'b0;
                tick_timer  = report_period;
                mode        = MODE_DRIVING;
              end else begin
                tick_timer = tick_timer - 10'd1;
              end
            end
            MODE_DRIVING: begin
              drive_level = 1'b0;
              bump_level  = 1'b1;
              load_level  = 1'b0;
              if (report_due()) kind = RPT_POSITION;
            end
            MODE_STOPPED: begin
              drive_level = 1'b1;
              bump_level  = 1'b1;
              if (report_due()) kind = RPT_POSITION;
            end
            default: start_settling();
          endcase
        end
        // Quadrature decode: direction from the relation of the two levels
        OPC_CHG_A: begin
          level_a = b.pin_level;
          count   = (level_a != level_b) ? count + 16'd1 : count - 16'd1;
        end
        OPC_CHG_B: begin
          level_b = b.pin_level;
          count   = (level_a == level_b) ? count + 16'd1 : count - 16'd1;
        end
        default: begin
          if (b.command_code > CMD_STOP_UNLOAD) begin
            kind = RPT_NONE;
          end else if (mode != MODE_DRIVING && mode != MODE_STOPPED) begin
            kind = RPT_WRONG_STATE;
          end else begin
            case (b.command_code)
              CMD_START: begin
                start_bump();
                kind = RPT_STARTING;
              end
              CMD_CALIBRATE: begin
                start_settling();
                kind = RPT_CALIBRATING;
              end
              default: begin
                if (b.command_code == CMD_STOP_LOADED) load_level = 1'b1;
                else if (b.command_code == CMD_STOP_UNLOAD) load_level = 1'b0;
                drive_level = 1'b1;
                bump_level  = 1'b1;
                tick_timer  = report_period;
                mode        = MODE_STOPPED;
                kind        = RPT_STOPPED;
              end
            endcase
          end
        end
      endcase
      want = '{report_kind: kind, position: count, load_on: load_level,
               drive_pin: drive_level, bump_pin: bump_level};
      expected_reports.push_back(want);
    endfunction

    function void compare(string field, logic signed [16:0] want,
                          logic signed [16:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        error_count++;
      end
    endfunction

    function void check_report(out_beat_t got);
      out_beat_t want;
      if (expected_reports.size() == 0) begin
        $error("result beat with nothing expected: kind %0d position %0d",
               got.report_kind, got.position);
        error_count++;
        return;
      end
      want = expected_reports.pop_front();
      compare("report_kind", want.report_kind, got.report_kind);
      compare("position", want.position, got.position);
      compare("load_on", want.load_on, got.load_on);
      compare("drive_pin", want.drive_pin, got.drive_pin);
      compare("bump_pin", want.bump_pin, got.bump_pin);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_addr  = 1'b0;
  logic [15:0] cfg_wdata = '0;
  in_beat_t    in_data   = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  out_beat_t   out_data;
  logic        out_valid;
  logic        out_stall = 1'b0;

  bit          calm = 1'b0;
  int unsigned quiet_cycles = 0;
  report_scoreboard sb;

  pendulum_drive_controller u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_data_i   (in_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .out_data_o  (out_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_beat_t beat(logic [1:0] opc, logic lvl, logic [2:0] code);
    in_beat_t b;
    b.opcode       = opc;
    b.pin_level    = lvl;
    b.command_code = code;
    return b;
  endfunction

  // Encoder edge on a random channel, mostly a real transition
  function automatic in_beat_t draw_edge(in_beat_t b);
    logic current;
    if ($urandom_range(0, 1) == 0) begin
      b.opcode = OPC_CHG_A;
      current  = sb.level_a;
    end else begin
      b.opcode = OPC_CHG_B;
      current  = sb.level_b;
    end
    b.pin_level = ($urandom_range(0, 9) != 0) ? ~current : current;
    return b;
  endfunction

  // Pick the next beat from the predicted mode so that sequences run deep
  function automatic in_beat_t draw_beat();
    in_beat_t    b;
    int unsigned roll;
    int unsigned pick;
    bit          slow;
    b.opcode       = OPC_TICK;
    b.pin_level    = 1'($urandom_range(0, 1));
    b.command_code = 3'($urandom_range(int'(CMD_START), int'(CmdCodeLast)));
    roll = $urandom_range(0, 99);
    slow = sb.settle_samples > SlowSettle;
    if (sb.mode == MODE_DRIVING || sb.mode == MODE_STOPPED) begin
      if (roll < 60) begin
        b.opcode = OPC_TICK;
      end else if (roll < 86) begin
        b = draw_edge(b);
      end else begin
        b.opcode = OPC_CMD;
        pick = $urandom_range(0, 19);
        // restarts and recalibration are costly, keep them rare
        if (pick == 0) b.command_code = CMD_START;
        else if (pick == 1) b.command_code = slow ? CMD_STOP_KEEP : CMD_CALIBRATE;
        else if (pick < 17)
          b.command_code = 3'($urandom_range(int'(CMD_STOP_KEEP), int'(CMD_STOP_UNLOAD)));
        else
          b.command_code = 3'($urandom_range(int'(CmdUnknownFirst), int'(CmdCodeLast)));
      end
    end else begin
      if (roll < 80) b.opcode = OPC_TICK;
      else if (roll < 90 && !(slow && sb.mode == MODE_SETTLING)) b = draw_edge(b);
      else if (roll >= 90) b.opcode = OPC_CMD;
    end
    return b;
  endfunction

  // Offer one beat after a random gap; returns once it is accepted
  task automatic offer_beat(in_beat_t b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.predict_report(b);
  endtask

  // Stop offering and wait until every expected beat has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] settle, logic [9:0] interval);
    cfg_we    <= 1'b1;
    cfg_addr  <= CfgSettleSamples;
    cfg_wdata <= settle;
    @(posedge clk);
    sb.settle_samples = settle;
    cfg_addr  <= CfgReportInterval;
    cfg_wdata <= 16'(interval);
    @(posedge clk);
    sb.report_period = interval;
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [15:0] settle, logic [9:0] interval,
                           int unsigned n, bit quiet);
    // a long settle setting must not be entered mid-calibration
    while (settle > SlowSettle && sb.mode == MODE_SETTLING)
      offer_beat(beat(OPC_TICK, 1'b0, CMD_START));
    wait_drained();
    write_regs(settle, interval);
    calm = quiet;
    repeat (n) offer_beat(draw_beat());
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall per beat, one long hold-off to fill the block
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    bit          squeezed;
    taken    = 0;
    squeezed = 1'b0;
    wait (rst_n);
    forever begin
      // hold-off lands in the middle of a steady stream of input beats
      if (!squeezed && taken >= 200) begin
        squeezed = 1'b1;
        hold     = SqueezeCycles;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 6);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_report(out_data);
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    in_beat_t directed[$];
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: commands outside drive, quadrature steps, a short calibration
    write_regs(16'd3, 10'd4);
    directed = '{
      beat(OPC_CMD,   1'b0, CMD_START),        // wrong state before calibration
      beat(OPC_CMD,   1'b0, CmdCodeLast),      // unknown command
      beat(OPC_CHG_A, 1'b1, CMD_START),
      beat(OPC_CHG_B, 1'b1, CMD_START),
      beat(OPC_CHG_A, 1'b0, CMD_START),
      beat(OPC_CHG_B, 1'b0, CMD_START),
      beat(OPC_CHG_A, 1'b0, CMD_START),        // repeated level counts down
      beat(OPC_TICK,  1'b0, CMD_START),        // enters calibration
      beat(OPC_CMD,   1'b0, CMD_CALIBRATE),
      beat(OPC_CMD,   1'b1, CmdUnknownFirst),
      beat(OPC_TICK,  1'b0, CMD_START),
      beat(OPC_CHG_B, 1'b1, CMD_START),        // motion reloads the settle count
      beat(OPC_TICK,  1'b0, CMD_START),
      beat(OPC_TICK,  1'b0, CMD_START),
      beat(OPC_TICK,  1'b0, CMD_START),
      beat(OPC_TICK,  1'b0, CMD_START),
      beat(OPC_CMD,   1'b0, CMD_STOP_KEEP),
      beat(OPC_TICK,  1'b0, CMD_START),        // calibrated, bump begins
      beat(OPC_CMD,   1'b0, CMD_STOP_LOADED),
      beat(OPC_CMD,   1'b1, CMD_STOP_UNLOAD),
      beat(OPC_TICK,  1'b1, CmdCodeLast)
    };
    foreach (directed[i]) offer_beat(directed[i]);
    repeat (160) offer_beat(draw_beat());

    // Random phases across register settings, extremes included
    run_phase(16'd1,     10'd1,   120, 1'b1);
    run_phase(16'd0,     10'd0,   100, 1'b0);
    run_phase(16'hFFFF,  10'd999, 100, 1'b0);
    run_phase(16'd4,     10'd2,   130, 1'b1);
    run_phase(16'd2,     10'd7,   120, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pdc_pkg.sv
sv/pdc_front.sv
sv/pdc_queue.sv
sv/pdc_exec.sv
sv/pendulum_drive_controller.sv
sim/tb_pendulum_drive_controller.sv
